// ===== rtl/core/tked_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tked_pkg
// Shared types and constants for the terminal key escape decoder: parser
// states, key event codes, byte codes and the decode result struct.
// ----------------------------------------------------------------------------
package tked_pkg;

    // byte codes seen on the terminal link
    localparam logic [7:0] BYTE_BS     = 8'd8;
    localparam logic [7:0] BYTE_TAB    = 8'd9;
    localparam logic [7:0] BYTE_LF     = 8'd10;
    localparam logic [7:0] BYTE_ESC    = 8'd27;
    localparam logic [7:0] BYTE_DEL    = 8'd127;
    localparam logic [7:0] BYTE_BS_ALT = 8'd247;
    localparam logic [7:0] BYTE_LBRKT  = 8'h5B;  // '['
    localparam logic [7:0] BYTE_SS3    = 8'h4F;  // 'O'
    localparam logic [7:0] BYTE_TILDE  = 8'h7E;  // '~'
    localparam logic [7:0] BYTE_SEMI   = 8'h3B;  // ';'
    localparam logic [7:0] BYTE_A      = 8'h41;
    localparam logic [7:0] BYTE_B      = 8'h42;
    localparam logic [7:0] BYTE_C      = 8'h43;
    localparam logic [7:0] BYTE_D      = 8'h44;
    localparam logic [7:0] BYTE_F      = 8'h46;
    localparam logic [7:0] BYTE_H      = 8'h48;
    localparam logic [7:0] BYTE_1      = 8'h31;
    localparam logic [7:0] BYTE_3      = 8'h33;
    localparam logic [7:0] BYTE_4      = 8'h34;
    localparam logic [7:0] BYTE_5      = 8'h35;
    localparam logic [7:0] BYTE_6      = 8'h36;

    // parser states
    typedef enum logic [3:0] {
        ST_IDLE = 4'd0,
        ST_ESC  = 4'd1,
        ST_CSI  = 4'd2,
        ST_SS3  = 4'd3,
        ST_DEL  = 4'd4,
        ST_HOME = 4'd5,
        ST_END  = 4'd6,
        ST_PAGE = 4'd7,
        ST_MOD  = 4'd8,
        ST_MODK = 4'd9
    } parse_state_t;

    // key event codes
    typedef enum logic [3:0] {
        EV_CHAR   = 4'd0,
        EV_BACK   = 4'd1,
        EV_TAB    = 4'd2,
        EV_ENTER  = 4'd3,
        EV_UP     = 4'd4,
        EV_DOWN   = 4'd5,
        EV_RIGHT  = 4'd6,
        EV_LEFT   = 4'd7,
        EV_HOME   = 4'd8,
        EV_END    = 4'd9,
        EV_DELETE = 4'd10
    } key_event_t;

    // outcome of decoding one byte
    typedef struct packed {
        parse_state_t next_state;
        logic         ev_valid;
        key_event_t   ev;
        logic [7:0]   ch;
    } decode_t;

endpackage

// ===== rtl/core/tked_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tked_if
// Valid/ready channels of the decoder: a byte channel in, a key event
// channel out.
// ----------------------------------------------------------------------------
interface tked_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface tked_key_if;
    logic       valid;
    logic       ready;
    logic [3:0] key_event;
    logic [7:0] char_value;

    modport source (output valid, output key_event, output char_value, input ready);
    modport sink   (input valid, input key_event, input char_value, output ready);
endinterface

// ===== rtl/core/tked_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tked_decoder
// Next-state and event logic of the escape sequence parser for one byte.
// ----------------------------------------------------------------------------
module tked_decoder
(
    input  tked_pkg::parse_state_t state,
    input  logic [7:0]             data,
    output tked_pkg::decode_t      dec
);

    // per-state decode
    always_comb
    begin
        dec.next_state = tked_pkg::ST_IDLE;
        dec.ev_valid   = 1'b0;
        dec.ev         = tked_pkg::EV_CHAR;
        dec.ch         = 8'd0;
        case (state)
            tked_pkg::ST_IDLE:
            begin
                dec.ev_valid = 1'b1;
                if (data inside {tked_pkg::BYTE_BS, tked_pkg::BYTE_DEL, tked_pkg::BYTE_BS_ALT})
                begin
                    dec.ev = tked_pkg::EV_BACK;
                end
                else if (data == tked_pkg::BYTE_TAB)
                begin
                    dec.ev = tked_pkg::EV_TAB;
                end
                else if (data == tked_pkg::BYTE_LF)
                begin
                    dec.ev = tked_pkg::EV_ENTER;
                end
                else if (data == tked_pkg::BYTE_ESC)
                begin
                    dec.ev_valid   = 1'b0;
                    dec.next_state = tked_pkg::ST_ESC;
                end
                else
                begin
                    dec.ch = data;
                end
            end
            tked_pkg::ST_ESC:
            begin
                if (data == tked_pkg::BYTE_LBRKT)
                begin
                    dec.next_state = tked_pkg::ST_CSI;
                end
                else if (data == tked_pkg::BYTE_SS3)
                begin
                    dec.next_state = tked_pkg::ST_SS3;
                end
            end
            tked_pkg::ST_CSI:
            begin
                case (data)
                    tked_pkg::BYTE_A:
                    begin
                        dec.ev_valid = 1'b1;
                        dec.ev       = tked_pkg::EV_UP;
                    end
                    tked_pkg::BYTE_B:
                    begin
                        dec.ev_valid = 1'b1;
                        dec.ev       = tked_pkg::EV_DOWN;
                    end
                    tked_pkg::BYTE_C:
                    begin
                        dec.ev_valid = 1'b1;
                        dec.ev       = tked_pkg::EV_RIGHT;
                    end
                    tked_pkg::BYTE_D:
                    begin
                        dec.ev_valid = 1'b1;
                        dec.ev       = tked_pkg::EV_LEFT;
                    end
                    tked_pkg::BYTE_H:
                    begin
                        dec.ev_valid = 1'b1;
                        dec.ev       = tked_pkg::EV_HOME;
                    end
                    tked_pkg::BYTE_F:
                    begin
                        dec.ev_valid = 1'b1;
                        dec.ev       = tked_pkg::EV_END;
                    end
                    tked_pkg::BYTE_3: dec.next_state = tked_pkg::ST_DEL;
                    tked_pkg::BYTE_1: dec.next_state = tked_pkg::ST_HOME;
                    tked_pkg::BYTE_4: dec.next_state = tked_pkg::ST_END;
                    tked_pkg::BYTE_5,
                    tked_pkg::BYTE_6: dec.next_state = tked_pkg::ST_PAGE;
                    default: dec.next_state = tked_pkg::ST_IDLE;
                endcase
            end
            tked_pkg::ST_SS3:
            begin
                if (data == tked_pkg::BYTE_H)
                begin
                    dec.ev_valid = 1'b1;
                    dec.ev       = tked_pkg::EV_HOME;
                end
                else if (data == tked_pkg::BYTE_F)
                begin
                    dec.ev_valid = 1'b1;
                    dec.ev       = tked_pkg::EV_END;
                end
            end
            tked_pkg::ST_DEL:
            begin
                if (data == tked_pkg::BYTE_TILDE)
                begin
                    dec.ev_valid = 1'b1;
                    dec.ev       = tked_pkg::EV_DELETE;
                end
                else if (data == tked_pkg::BYTE_SEMI)
                begin
                    dec.next_state = tked_pkg::ST_MOD;
                end
            end
            tked_pkg::ST_HOME:
            begin
                if (data == tked_pkg::BYTE_TILDE)
                begin
                    dec.ev_valid = 1'b1;
                    dec.ev       = tked_pkg::EV_HOME;
                end
                else if (data == tked_pkg::BYTE_SEMI)
                begin
                    dec.next_state = tked_pkg::ST_MOD;
                end
            end
            tked_pkg::ST_END:
            begin
                if (data == tked_pkg::BYTE_TILDE)
                begin
                    dec.ev_valid = 1'b1;
                    dec.ev       = tked_pkg::EV_END;
                end
            end
            tked_pkg::ST_PAGE:
            begin
                if (data == tked_pkg::BYTE_SEMI)
                begin
                    dec.next_state = tked_pkg::ST_MOD;
                end
            end
            tked_pkg::ST_MOD:
            begin
                if (data inside {tked_pkg::BYTE_3, tked_pkg::BYTE_5, tked_pkg::BYTE_A,
                                 tked_pkg::BYTE_B, tked_pkg::BYTE_C, tked_pkg::BYTE_D})
                begin
                    dec.next_state = tked_pkg::ST_MODK;
                end
            end
            // modifier tail byte and unused codes: absorb, back to idle
            default: dec.next_state = tked_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/terminal_key_escape_decoder.sv =====
`timescale 1ns / 1ps
// Path: an accepted byte is held in the input register, then decoded into the
// result register, which offers its key event on the output.
// Throughput: one byte per cycle while the result register is empty or being
// drained, set by the single parser state register that is updated as each
// byte leaves the input register.
// Reset: asynchronous, clears both valid flags and returns the parser to idle.
// ----------------------------------------------------------------------------
// terminal_key_escape_decoder
// Decodes a stream of terminal bytes, including ANSI/VT100 escape sequences,
// into key events and character events.
// ----------------------------------------------------------------------------
module terminal_key_escape_decoder
(
    input  logic             clk,
    input  logic             rst_n,
    tked_byte_if.sink        rx,
    tked_key_if.source       key
);

    logic                   in_valid_reg;
    logic                   in_valid_next;
    logic [7:0]             in_byte_reg;
    tked_pkg::parse_state_t state_reg;
    tked_pkg::parse_state_t state_next;
    logic                   res_valid_reg;
    logic                   res_valid_next;
    tked_pkg::key_event_t   res_event_reg;
    logic [7:0]             res_char_reg;
    logic                   res_ready;
    logic                   in_fire;
    logic                   dec_fire;
    tked_pkg::decode_t      dec;

    // handshake: the result register takes a new entry when empty or being drained
    assign res_ready = !res_valid_reg || key.ready;
    assign dec_fire  = in_valid_reg && res_ready;
    assign rx.ready  = !in_valid_reg || res_ready;
    assign in_fire   = rx.valid && rx.ready;

    // decode of the registered byte
    tked_decoder u_decoder
    (
        .state (state_reg),
        .data  (in_byte_reg),
        .dec   (dec)
    );

    // next values of control state
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (dec_fire)
        begin
            in_valid_next = 1'b0;
        end

        state_next = dec_fire ? dec.next_state : state_reg;

        res_valid_next = res_valid_reg;
        if (dec_fire)
        begin
            res_valid_next = dec.ev_valid;
        end
        else if (key.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            state_reg     <= tked_pkg::ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_byte_reg <= rx.in_byte;
        end
        if (dec_fire && dec.ev_valid)
        begin
            res_event_reg <= dec.ev;
            res_char_reg  <= dec.ch;
        end
    end

    assign key.valid      = res_valid_reg;
    assign key.key_event  = res_event_reg;
    assign key.char_value = res_char_reg;

    // the input side only stalls while a byte is held
    a_stall_holds_byte: assert property (@(posedge clk) disable iff (!rst_n)
        !rx.ready |-> in_valid_reg)
        else $error("input stalled with empty input register");

    // only char events carry a byte value
    a_char_only: assert property (@(posedge clk) disable iff (!rst_n)
        key.valid && key.key_event != tked_pkg::EV_CHAR |-> key.char_value == 8'd0)
        else $error("non-char event with non-zero char value");

    // ESC in idle opens a sequence without an event
    a_esc_opens: assert property (@(posedge clk) disable iff (!rst_n)
        dec_fire && state_reg == tked_pkg::ST_IDLE && in_byte_reg == tked_pkg::BYTE_ESC
        |=> state_reg == tked_pkg::ST_ESC && !res_valid_reg)
        else $error("ESC did not open a sequence");

    // the modifier tail byte always ends the sequence
    a_mod_tail: assert property (@(posedge clk) disable iff (!rst_n)
        dec_fire && state_reg == tked_pkg::ST_MODK |=> state_reg == tked_pkg::ST_IDLE)
        else $error("modifier tail did not return to idle");

    // the parser state only moves when a byte is decoded
    a_state_moves: assert property (@(posedge clk) disable iff (!rst_n)
        !dec_fire |=> $stable(state_reg))
        else $error("parser state changed without a byte");

endmodule
